FILE: hw/rtl/v3alu_pkg.sv
// shared types, opcodes and saturation helper for the vector alu
package v3alu_pkg;

   localparam int PORT_BITS     = 32;
   localparam int CMD_BITS      = 4;
   localparam int DEF_FRAC_BITS = 16;
   localparam int DEF_WORD_BITS = 32;
   localparam int SAT_BITS      = 2 * PORT_BITS + 4;

   typedef enum logic [CMD_BITS-1:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_SCALE   = 4'd3,
      OP_DOT     = 4'd4,
      OP_CROSS   = 4'd5,
      OP_LENGTH  = 4'd6,
      OP_NORM    = 4'd7,
      OP_REFLECT = 4'd8
   } op_type;

   typedef struct packed {
      logic                        hit;
      logic signed [PORT_BITS-1:0] val;
   } sat_type;

   function automatic sat_type sat_word(input logic signed [SAT_BITS-1:0] v, input int ew);
      logic signed [SAT_BITS-1:0] hi;
      logic signed [SAT_BITS-1:0] lo;
      sat_type                    r;
      hi = signed'((SAT_BITS'(1) << (ew - 1)) - SAT_BITS'(1));
      lo = -hi - signed'(SAT_BITS'(1));
      r.hit = 1'b0;
      r.val = v[PORT_BITS-1:0];
      if (v > hi) begin
         r.hit = 1'b1;
         r.val = hi[PORT_BITS-1:0];
      end else if (v < lo) begin
         r.hit = 1'b1;
         r.val = lo[PORT_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/v3alu_delay.sv
// fixed-depth payload delay line with shared advance enable
module v3alu_delay import v3alu_pkg::*; #(
   parameter int WIDTH = PORT_BITS,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int j = 1; j < DEPTH; j++) begin
            tap_ff[j] <= tap_ff[j-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

FILE: hw/rtl/v3alu_lane.sv
// one component lane: multipliers, add/sub and per-lane clamping
module v3alu_lane import v3alu_pkg::*; #(
   parameter int EW = DEF_WORD_BITS,
   parameter int F  = DEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   en,
   input  op_type                 cmd,
   input  logic signed [EW-1:0]   a,
   input  logic signed [EW-1:0]   b,
   input  logic signed [EW-1:0]   a_n1,
   input  logic signed [EW-1:0]   b_n2,
   input  logic signed [EW-1:0]   a_n2,
   input  logic signed [EW-1:0]   b_n1,
   input  logic signed [EW-1:0]   k,
   output logic signed [EW-1:0]   res,
   output logic                   hit,
   output logic signed [2*EW-F-1:0] trunc,
   output logic [2*EW-2:0]        sq
);

   localparam int PW = 2 * EW;
   localparam int TW = 2 * EW - F;

   logic signed [EW-1:0] op_a;
   logic signed [EW-1:0] op_b;
   logic signed [PW-1:0] m1_in, m1_ff;
   logic signed [PW-1:0] m2_in, m2_ff;
   logic signed [EW:0]   as_in, as_ff;
   op_type               cmd_ff;

   logic signed [PW-1:0] t1;
   logic signed [PW-1:0] t2;
   sat_type              st;

   always_comb begin
      op_a = a;
      op_b = b;
      case (cmd)
         OP_SCALE: begin
            op_a = k;
            op_b = a;
         end
         OP_LENGTH, OP_NORM: begin
            op_a = a;
            op_b = a;
         end
         OP_CROSS: begin
            op_a = a_n1;
            op_b = b_n2;
         end
         default: begin
            op_a = a;
            op_b = b;
         end
      endcase
      m1_in = PW'(op_a) * PW'(op_b);
      m2_in = PW'(a_n2) * PW'(b_n1);
      as_in = (cmd == OP_SUB) ? ((EW+1)'(a) - (EW+1)'(b)) : ((EW+1)'(a) + (EW+1)'(b));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         as_ff  <= as_in;
         cmd_ff <= cmd;
      end
   end

   always_comb begin
      t1 = m1_ff >>> F;
      t2 = m2_ff >>> F;
      case (cmd_ff)
         OP_ADD, OP_SUB:   st = sat_word(SAT_BITS'(as_ff), EW);
         OP_MUL, OP_SCALE: st = sat_word(SAT_BITS'(t1), EW);
         OP_CROSS:         st = sat_word(SAT_BITS'(t1) - SAT_BITS'(t2), EW);
         default:          st = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res   <= st.val[EW-1:0];
         hit   <= st.hit;
         trunc <= t1[TW-1:0];
         sq    <= m1_ff[PW-2:0];
      end
   end

endmodule

FILE: hw/rtl/v3alu_sqrt.sv
// pipelined integer square root, one result bit per stage
module v3alu_sqrt import v3alu_pkg::*; #(
   parameter int EW = DEF_WORD_BITS
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*EW-1:0] n,
   output logic [EW-1:0]   root
);

   localparam int SQW = 2 * EW;

   logic [SQW-1:0] n_ff    [EW];
   logic [SQW-1:0] n_in    [EW];
   logic [EW+1:0]  rem_ff  [EW];
   logic [EW+1:0]  rem_in  [EW];
   logic [EW-1:0]  root_ff [EW];
   logic [EW-1:0]  root_in [EW];

   always_comb begin
      logic [SQW-1:0] n_prev;
      logic [EW+1:0]  rem_prev;
      logic [EW-1:0]  root_prev;
      logic [EW+1:0]  rem_t;
      logic [EW+1:0]  test;
      for (int j = 0; j < EW; j++) begin
         n_prev    = (j == 0) ? n  : n_ff[(j == 0) ? 0 : j-1];
         rem_prev  = (j == 0) ? '0 : rem_ff[(j == 0) ? 0 : j-1];
         root_prev = (j == 0) ? '0 : root_ff[(j == 0) ? 0 : j-1];
         rem_t     = {rem_prev[EW-1:0], n_prev[SQW-1 -: 2]};
         test      = {root_prev, 2'b01};
         n_in[j]   = n_prev << 2;
         if (rem_t >= test) begin
            rem_in[j]  = rem_t - test;
            root_in[j] = {root_prev[EW-2:0], 1'b1};
         end else begin
            rem_in[j]  = rem_t;
            root_in[j] = {root_prev[EW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < EW; j++) begin
            n_ff[j]    <= n_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
         end
      end
   end

   assign root = root_ff[EW-1];

endmodule

FILE: hw/rtl/v3alu_div.sv
// pipelined restoring divider for normalize, one quotient bit per stage
module v3alu_div import v3alu_pkg::*; #(
   parameter int EW = DEF_WORD_BITS,
   parameter int F  = DEF_FRAC_BITS
) (
   input  logic          clock,
   input  logic          en,
   input  logic [EW-1:0] mag,
   input  logic          sgn,
   input  logic [EW-1:0] d,
   output logic [F:0]    q,
   output logic          sgn_o,
   output logic [EW-1:0] d_o
);

   localparam int QB = F + 1;

   logic [EW-1:0] rem_ff [QB];
   logic [EW-1:0] rem_in [QB];
   logic [QB-1:0] q_ff   [QB];
   logic [QB-1:0] q_in   [QB];
   logic [EW-1:0] d_ff   [QB];
   logic          s_ff   [QB];

   always_comb begin
      logic [EW:0]   rem_t;
      logic [EW-1:0] d_prev;
      logic [QB-1:0] q_prev;
      for (int j = 0; j < QB; j++) begin
         rem_t  = (j == 0) ? {1'b0, mag} : {rem_ff[(j == 0) ? 0 : j-1], 1'b0};
         d_prev = (j == 0) ? d : d_ff[(j == 0) ? 0 : j-1];
         q_prev = (j == 0) ? '0 : q_ff[(j == 0) ? 0 : j-1];
         if (rem_t >= {1'b0, d_prev}) begin
            rem_in[j] = EW'(rem_t - {1'b0, d_prev});
            q_in[j]   = {q_prev[QB-2:0], 1'b1};
         end else begin
            rem_in[j] = rem_t[EW-1:0];
            q_in[j]   = {q_prev[QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         d_ff[0]   <= d;
         s_ff[0]   <= sgn;
         for (int j = 1; j < QB; j++) begin
            rem_ff[j] <= rem_in[j];
            q_ff[j]   <= q_in[j];
            d_ff[j]   <= d_ff[j-1];
            s_ff[j]   <= s_ff[j-1];
         end
      end
   end

   assign q     = q_ff[QB-1];
   assign sgn_o = s_ff[QB-1];
   assign d_o   = d_ff[QB-1];

endmodule

FILE: hw/rtl/vector3_fixed_point_alu.sv
// three-component q-format vector alu, top level
// every opcode runs through the same pipeline, so results leave in request order
// throughput: one word per cycle, fixed by a fully pipelined square root (one bit a stage)
// and three lane dividers (one quotient bit a stage); the whole pipe holds while a result waits
// reset: synchronous, clears the valid pipeline only; payload registers are not reset
module vector3_fixed_point_alu import v3alu_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7*PORT_BITS-1:0] req_tdata,  // ax, ay, az, bx, by, bz, scale
   input  logic [CMD_BITS-1:0]    req_tuser,  // cmd
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [4*PORT_BITS-1:0] rsp_tdata,  // rx, ry, rz, scalar_out
   output logic [1:0]             rsp_tuser   // zero_length, saturated
);

   localparam int EW  = (WORD_BITS < PORT_BITS) ? WORD_BITS : PORT_BITS;
   localparam int F   = FRAC_BITS;
   localparam int QB  = F + 1;
   localparam int PW  = 2 * EW;
   localparam int TW  = 2 * EW - F;
   localparam int DSW = TW + 2;
   localparam int LAT = 4 + EW + QB;
   localparam int MW  = CMD_BITS + 4 * EW + 1;

   logic en;
   logic valid_ff [LAT];

   logic signed [EW-1:0]   ain  [3];
   logic signed [EW-1:0]   bin  [3];
   logic signed [EW-1:0]   kin;
   logic [3*EW-1:0]        a_pk;
   logic [3*EW-1:0]        b_pk;

   logic signed [EW-1:0]   lres [3];
   logic                   lhit [3];
   logic signed [TW-1:0]   ltr  [3];
   logic [PW-2:0]          lsq  [3];

   assign en         = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT; j++) valid_ff[j] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int j = 1; j < LAT; j++) valid_ff[j] <= valid_ff[j-1];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ain[i] = signed'(req_tdata[i*PORT_BITS +: EW]);
         bin[i] = signed'(req_tdata[(3+i)*PORT_BITS +: EW]);
      end
      kin  = signed'(req_tdata[6*PORT_BITS +: EW]);
      a_pk = {ain[2], ain[1], ain[0]};
      b_pk = {bin[2], bin[1], bin[0]};
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      v3alu_lane #(.EW(EW), .F(F)) u_lane (
         .clock (clock),
         .en    (en),
         .cmd   (op_type'(req_tuser)),
         .a     (ain[i]),
         .b     (bin[i]),
         .a_n1  (ain[(i+1)%3]),
         .b_n2  (bin[(i+2)%3]),
         .a_n2  (ain[(i+2)%3]),
         .b_n1  (bin[(i+1)%3]),
         .k     (kin),
         .res   (lres[i]),
         .hit   (lhit[i]),
         .trunc (ltr[i]),
         .sq    (lsq[i])
      );
   end

   // side paths
   logic [CMD_BITS-1:0] cmd6;
   logic [3*EW+2:0]     lane6;
   logic [3*EW-1:0]     b4_pk;
   logic [3*EW-1:0]     a5_pk;
   logic [3*EW-1:0]     ad_pk;

   v3alu_delay #(.WIDTH(CMD_BITS), .DEPTH(6)) u_dly_cmd (
      .clock(clock), .en(en), .d(req_tuser), .q(cmd6));
   v3alu_delay #(.WIDTH(3*EW+3), .DEPTH(4)) u_dly_lane (
      .clock(clock), .en(en),
      .d({lhit[2], lhit[1], lhit[0], lres[2], lres[1], lres[0]}), .q(lane6));
   v3alu_delay #(.WIDTH(3*EW), .DEPTH(4)) u_dly_b (
      .clock(clock), .en(en), .d(b_pk), .q(b4_pk));
   v3alu_delay #(.WIDTH(3*EW), .DEPTH(5)) u_dly_a (
      .clock(clock), .en(en), .d(a_pk), .q(a5_pk));
   v3alu_delay #(.WIDTH(3*EW), .DEPTH(3+EW)) u_dly_adiv (
      .clock(clock), .en(en), .d(a_pk), .q(ad_pk));

   // dot product and sum of squares
   logic signed [DSW-1:0] dsum_ff;
   logic [PW-1:0]         sq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dsum_ff <= DSW'(ltr[0]) + DSW'(ltr[1]) + DSW'(ltr[2]);
         sq_ff   <= PW'(lsq[0]) + PW'(lsq[1]) + PW'(lsq[2]);
      end
   end

   sat_type              sat1;
   sat_type              sat2;
   logic signed [EW-1:0] d_ff, d2_ff;
   logic                 dh1_ff, dh2_ff;

   always_comb begin
      sat1 = sat_word(SAT_BITS'(dsum_ff), EW);
      sat2 = sat_word(SAT_BITS'(sat1.val) <<< 1, EW);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff   <= sat1.val[EW-1:0];
         d2_ff  <= sat2.val[EW-1:0];
         dh1_ff <= sat1.hit;
         dh2_ff <= sat1.hit | sat2.hit;
      end
   end

   // reflect
   logic signed [PW-1:0] q_ff [3];
   logic signed [EW-1:0] d5_ff;
   logic                 dh1_5_ff, dh2_5_ff;
   logic signed [EW-1:0] b4 [3];
   logic signed [EW-1:0] a5 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b4[i] = signed'(b4_pk[i*EW +: EW]);
         a5[i] = signed'(a5_pk[i*EW +: EW]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) q_ff[i] <= PW'(d2_ff) * PW'(b4[i]);
         d5_ff    <= d_ff;
         dh1_5_ff <= dh1_ff;
         dh2_5_ff <= dh2_ff;
      end
   end

   sat_type              rs [3];
   logic signed [EW-1:0] rr_ff [3];
   logic                 rh_ff;
   logic signed [EW-1:0] d6_ff;
   logic                 dh1_6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rs[i] = sat_word(SAT_BITS'(a5[i]) - SAT_BITS'(q_ff[i] >>> F), EW);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) rr_ff[i] <= rs[i].val[EW-1:0];
         rh_ff    <= dh2_5_ff | rs[0].hit | rs[1].hit | rs[2].hit;
         d6_ff    <= d5_ff;
         dh1_6_ff <= dh1_5_ff;
      end
   end

   // merge of lane, dot and reflect results
   logic [MW-1:0] main6;
   logic [MW-1:0] maind;

   always_comb begin
      main6 = '0;
      case (op_type'(cmd6))
         OP_ADD, OP_SUB, OP_MUL, OP_SCALE, OP_CROSS: begin
            main6 = {cmd6, EW'(0), lane6[3*EW-1:0], |lane6[3*EW +: 3]};
         end
         OP_DOT: begin
            main6 = {cmd6, d6_ff, EW'(0), EW'(0), EW'(0), dh1_6_ff};
         end
         OP_REFLECT: begin
            main6 = {cmd6, EW'(0), rr_ff[2], rr_ff[1], rr_ff[0], rh_ff};
         end
         default: begin
            main6 = {cmd6, {(4*EW+1){1'b0}}};
         end
      endcase
   end

   v3alu_delay #(.WIDTH(MW), .DEPTH(EW+QB-3)) u_dly_main (
      .clock(clock), .en(en), .d(main6), .q(maind));

   // length and normalize
   logic [EW-1:0] root;
   logic [F:0]    nq   [3];
   logic          nsgn [3];
   logic [EW-1:0] nd   [3];
   logic signed [EW-1:0] adv [3];

   v3alu_sqrt #(.EW(EW)) u_sqrt (
      .clock(clock), .en(en), .n(sq_ff), .root(root));

   for (genvar i = 0; i < 3; i++) begin : g_div
      assign adv[i] = signed'(ad_pk[i*EW +: EW]);
      v3alu_div #(.EW(EW), .F(F)) u_div (
         .clock (clock),
         .en    (en),
         .mag   (adv[i][EW-1] ? EW'(-adv[i]) : EW'(adv[i])),
         .sgn   (adv[i][EW-1]),
         .d     (root),
         .q     (nq[i]),
         .sgn_o (nsgn[i]),
         .d_o   (nd[i])
      );
   end

   // output stage
   logic signed [PORT_BITS-1:0] r_in [3];
   logic signed [PORT_BITS-1:0] r_ff [3];
   logic signed [PORT_BITS-1:0] s_in, s_ff;
   logic                        zl_in, zl_ff;
   logic                        hit_in, hit_ff;
   sat_type                     ls;
   sat_type                     ns [3];
   logic signed [SAT_BITS-1:0]  nv;

   always_comb begin
      ls = sat_word(SAT_BITS'({1'b0, nd[0]}), EW);
      for (int i = 0; i < 3; i++) begin
         nv    = SAT_BITS'({1'b0, nq[i]});
         ns[i] = sat_word(nsgn[i] ? -nv : nv, EW);
      end
      for (int i = 0; i < 3; i++) r_in[i] = PORT_BITS'(signed'(maind[1 + i*EW +: EW]));
      s_in   = PORT_BITS'(signed'(maind[1 + 3*EW +: EW]));
      zl_in  = 1'b0;
      hit_in = maind[0];
      case (op_type'(maind[MW-1 -: CMD_BITS]))
         OP_LENGTH: begin
            s_in   = ls.val;
            hit_in = ls.hit;
         end
         OP_NORM: begin
            if (nd[0] == '0) begin
               zl_in = 1'b1;
               for (int i = 0; i < 3; i++) r_in[i] = '0;
               hit_in = 1'b0;
            end else begin
               for (int i = 0; i < 3; i++) r_in[i] = ns[i].val;
               hit_in = ns[0].hit | ns[1].hit | ns[2].hit;
            end
         end
         default: begin
            zl_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) r_ff[i] <= r_in[i];
         s_ff   <= s_in;
         zl_ff  <= zl_in;
         hit_ff <= hit_in;
      end
   end

   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata  = {s_ff, r_ff[2], r_ff[1], r_ff[0]};
   assign rsp_tuser  = {hit_ff, zl_ff};

endmodule
